// File: design/ebc_pkg.sv
package ebc_pkg;

    localparam int MAX_TASKS      = 16;
    localparam int SLOT_W         = $clog2(MAX_TASKS);
    localparam int UTIL_FRAC_BITS = 16;
    localparam int UTIL_W         = UTIL_FRAC_BITS + 1;
    localparam int ID_W           = 22;
    localparam int BW_W           = 23;
    localparam int TSUM_W         = 32 + SLOT_W;
    // utilization sums: at most MAX_TASKS entries of 1.0 each
    localparam int USUM_W         = UTIL_W + SLOT_W;
    // signed excess: bandwidth and sums with a sign bit
    localparam int EXC_W          = ((BW_W > USUM_W) ? BW_W : USUM_W) + 2;
    localparam logic [BW_W-1:0] BW_RESET = BW_W'(62259);

    localparam logic [1:0] KIND_ADD_FIXED = 2'd0;
    localparam logic [1:0] KIND_ADD_DYN   = 2'd1;
    localparam logic [1:0] KIND_REMOVE    = 2'd2;
    localparam logic [1:0] KIND_RECOMPUTE = 2'd3;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] task_id;
        logic [31:0]     runtime;
        logic [31:0]     deadline;
        logic [31:0]     period;
    } in_word_t;

    typedef struct packed {
        logic [ID_W-1:0] out_task_id;
        logic [31:0]     out_period;
        logic [31:0]     out_deadline;
        logic [31:0]     out_runtime;
        logic            last;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;       // capture the input word
        logic div_start;     // start a division
        logic [1:0] div_sel; // which division
        logic lookup;        // register the slot search
        logic write_fixed;
        logic write_dyn;
        logic remove;
        logic clr_sums;
        logic acc_slot;      // add slot (index) to sums
        logic calc_excess;
        logic mul_start;     // runtime multiply for slot
        logic emit_fixed;
        logic emit_dyn;      // load output register with slot result
        logic [SLOT_W-1:0] slot;
    } ctrl_t;

    localparam logic [1:0] DIV_UTIL  = 2'd0;
    localparam logic [1:0] DIV_SHARE = 2'd1;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] kind;
        logic div_done;
        logic mul_done;
        logic slot_dyn_valid;
        logic is_last_slot;
        logic compress;
        logic out_busy;
    } stat_t;

endpackage

// File: design/ebc_div.sv
// Restoring divider, one quotient bit per cycle, 64/48 unsigned
module ebc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg, q_next;
    logic [48:0] r_reg, r_next;
    logic [47:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[47:0], q_reg[63]};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule

// File: design/ebc_datapath.sv
// Task tables, sums, shared divider and multiplier, output register
module ebc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ebc_pkg::ctrl_t       ctrl,
    output ebc_pkg::stat_t       stat,
    input  ebc_pkg::in_word_t    s_data,
    input  logic                 cfg_we,
    input  logic [ebc_pkg::BW_W-1:0] cfg_wdata,
    output ebc_pkg::out_word_t   m_data,
    output logic                 m_valid,
    input  logic                 m_ready
);
    localparam int N  = ebc_pkg::MAX_TASKS;
    localparam int SW = ebc_pkg::SLOT_W;
    localparam int UW = ebc_pkg::UTIL_W;
    localparam int F  = ebc_pkg::UTIL_FRAC_BITS;
    localparam int EW = ebc_pkg::EXC_W;

    ebc_pkg::in_word_t in_reg;
    logic [ebc_pkg::BW_W-1:0] bw_reg;

    logic [N-1:0] fv_reg, dv_reg;
    logic [ebc_pkg::ID_W-1:0] ft_reg [N];
    logic [UW-1:0] fu_reg [N];
    logic [ebc_pkg::ID_W-1:0] dt_reg [N];
    logic [UW-1:0] du_reg [N];
    logic [31:0] dp_reg [N];
    logic [31:0] dr_reg [N];

    logic [ebc_pkg::USUM_W-1:0] uf_reg, ud_reg;
    logic [ebc_pkg::TSUM_W-1:0] ts_reg;
    logic [EW-1:0] exc_reg;
    logic compress_reg;
    logic [SW-1:0] last_slot_reg;
    logic [SW:0] fslot_reg, dslot_reg; // msb: none

    logic [UW-1:0] util_reg;
    logic [63:0] prod_reg;
    logic mul_done_reg;

    // divider operand select
    logic div_done;
    logic [63:0] quo, dvd;
    logic [47:0] dvs;
    logic [EW+31:0] ep;

    assign ep = exc_reg * dp_reg[ctrl.slot];
    always_comb begin
        unique case (ctrl.div_sel)
            ebc_pkg::DIV_SHARE: begin
                dvd = 64'(ep);
                dvs = 48'(ts_reg);
            end
            default: begin
                dvd = {in_reg.runtime, 32'd0} >> (32 - F);
                dvs = 48'(in_reg.period);
            end
        endcase
    end

    ebc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(ctrl.div_start),
        .dividend(dvd), .divisor(dvs), .done(div_done), .quotient(quo)
    );

    // saturated utilization from quotient
    logic [UW-1:0] util_sat;
    always_comb begin
        if (in_reg.period == 32'd0 || quo > 64'(1 << F)) util_sat = UW'(1 << F);
        else util_sat = quo[UW-1:0];
    end

    // slot search: match first, else lowest free
    function automatic logic [SW:0] find(input logic [N-1:0] v,
                                         input logic [ebc_pkg::ID_W-1:0] ids [N],
                                         input logic [ebc_pkg::ID_W-1:0] id);
        logic [SW:0] r;
        r = {1'b1, {SW{1'b0}}};
        for (int i = N - 1; i >= 0; i--)
            if (!v[i]) r = {1'b0, SW'(i)};
        for (int i = N - 1; i >= 0; i--)
            if (v[i] && ids[i] == id) r = {1'b0, SW'(i)};
        return r;
    endfunction

    // new utilization of the slot being emitted
    logic signed [EW+1:0] unew;
    logic [EW+1:0] share_c;
    assign share_c = (ts_reg == '0) ? '0 : (EW+2)'(quo);
    assign unew = $signed({2'b0, {(EW-UW){1'b0}}, du_reg[ctrl.slot]}) - $signed(share_c);

    // runtime product: positive utilization is at most 1.0
    logic [UW+31:0] prod_c;
    assign prod_c = unew[UW-1:0] * dp_reg[ctrl.slot];

    always_ff @(posedge aclk) begin
        if (ctrl.load_in) in_reg <= s_data;
        if (ctrl.lookup) begin
            fslot_reg <= find(fv_reg, ft_reg, in_reg.task_id);
            dslot_reg <= find(dv_reg, dt_reg, in_reg.task_id);
        end
        if (div_done) util_reg <= util_sat;
        if (ctrl.write_fixed && !fslot_reg[SW]) begin
            ft_reg[fslot_reg[SW-1:0]] <= in_reg.task_id;
            fu_reg[fslot_reg[SW-1:0]] <= util_reg;
        end
        if (ctrl.write_dyn && !dslot_reg[SW]) begin
            dt_reg[dslot_reg[SW-1:0]] <= in_reg.task_id;
            du_reg[dslot_reg[SW-1:0]] <= util_reg;
            dp_reg[dslot_reg[SW-1:0]] <= in_reg.period;
            dr_reg[dslot_reg[SW-1:0]] <= in_reg.runtime;
        end
        if (ctrl.clr_sums) begin
            uf_reg <= '0;
            ud_reg <= '0;
            ts_reg <= '0;
        end else if (ctrl.acc_slot) begin
            if (fv_reg[ctrl.slot]) uf_reg <= uf_reg + ebc_pkg::USUM_W'(fu_reg[ctrl.slot]);
            if (dv_reg[ctrl.slot]) begin
                ud_reg <= ud_reg + ebc_pkg::USUM_W'(du_reg[ctrl.slot]);
                ts_reg <= ts_reg + ebc_pkg::TSUM_W'(dp_reg[ctrl.slot]);
                last_slot_reg <= ctrl.slot;
            end
        end
        if (ctrl.calc_excess) begin
            // excess = ud - (bw - uf)
            exc_reg <= EW'(ud_reg) + EW'(uf_reg) - EW'(bw_reg);
            compress_reg <= (EW'(ud_reg) + EW'(uf_reg)) > EW'(bw_reg);
        end
        if (ctrl.mul_start)
            prod_reg <= (unew <= 0) ? 64'd0 : 64'(prod_c);
        if (ctrl.emit_fixed) begin
            m_data.out_task_id  <= in_reg.task_id;
            m_data.out_period   <= in_reg.period;
            m_data.out_deadline <= in_reg.deadline;
            m_data.out_runtime  <= in_reg.runtime;
            m_data.last         <= 1'b1;
        end else if (ctrl.emit_dyn) begin
            m_data.out_task_id  <= dt_reg[ctrl.slot];
            m_data.out_period   <= dp_reg[ctrl.slot];
            m_data.out_deadline <= dp_reg[ctrl.slot];
            m_data.out_runtime  <= compress_reg ? prod_reg[F+31:F] : dr_reg[ctrl.slot];
            m_data.last         <= (ctrl.slot == last_slot_reg);
        end
    end

    // control state: valid bits, bandwidth, output valid, multiply done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
            dv_reg <= '0;
            bw_reg <= ebc_pkg::BW_RESET;
            m_valid <= 1'b0;
            mul_done_reg <= 1'b0;
        end else begin
            if (cfg_we) bw_reg <= cfg_wdata;
            if (ctrl.write_fixed && !fslot_reg[SW]) fv_reg[fslot_reg[SW-1:0]] <= 1'b1;
            if (ctrl.write_dyn && !dslot_reg[SW]) dv_reg[dslot_reg[SW-1:0]] <= 1'b1;
            if (ctrl.remove)
                for (int i = 0; i < N; i++) begin
                    if (fv_reg[i] && ft_reg[i] == in_reg.task_id) fv_reg[i] <= 1'b0;
                    if (dv_reg[i] && dt_reg[i] == in_reg.task_id) dv_reg[i] <= 1'b0;
                end
            mul_done_reg <= ctrl.mul_start;
            if (ctrl.emit_fixed || ctrl.emit_dyn) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    assign stat.kind = in_reg.kind;
    assign stat.div_done = div_done;
    assign stat.mul_done = mul_done_reg;
    assign stat.slot_dyn_valid = dv_reg[ctrl.slot];
    assign stat.is_last_slot = (ctrl.slot == SW'(N - 1));
    assign stat.compress = compress_reg;
    assign stat.out_busy = m_valid && !m_ready;
endmodule

// File: design/ebc_ctrl.sv
// Sequencer: one input word at a time, walks slots on recompute
module ebc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ebc_pkg::stat_t stat,
    output ebc_pkg::ctrl_t ctrl
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_UDIV   = 4'd2;
    localparam logic [3:0] S_WRITE  = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_EXC    = 4'd5;
    localparam logic [3:0] S_SLOT   = 4'd6;
    localparam logic [3:0] S_SDIV   = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_OUTF   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [ebc_pkg::SLOT_W-1:0] slot_reg, slot_next;

    always_comb begin
        state_next = state_reg;
        slot_next = slot_reg;
        ctrl = '0;
        ctrl.slot = slot_reg;
        ctrl.div_sel = ebc_pkg::DIV_UTIL;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                ctrl.lookup = 1'b1;
                ctrl.clr_sums = 1'b1;
                slot_next = '0;
                unique case (stat.kind)
                    ebc_pkg::KIND_REMOVE: begin
                        ctrl.remove = 1'b1;
                        state_next = S_IDLE;
                    end
                    ebc_pkg::KIND_RECOMPUTE: state_next = S_SUM;
                    default: begin
                        ctrl.div_start = 1'b1;
                        state_next = S_UDIV;
                    end
                endcase
            end
            S_UDIV: if (stat.div_done) state_next = S_WRITE;
            S_WRITE: begin
                if (stat.kind == ebc_pkg::KIND_ADD_FIXED) begin
                    if (!stat.out_busy) begin
                        ctrl.write_fixed = 1'b1;
                        ctrl.emit_fixed = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    ctrl.write_dyn = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SUM: begin
                ctrl.acc_slot = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (stat.is_last_slot) state_next = S_EXC;
            end
            S_EXC: begin
                ctrl.calc_excess = 1'b1;
                state_next = S_SLOT;
            end
            S_SLOT: begin
                ctrl.div_sel = ebc_pkg::DIV_SHARE;
                if (!stat.slot_dyn_valid) begin
                    slot_next = slot_reg + 1'b1;
                    if (stat.is_last_slot) state_next = S_IDLE;
                end else if (stat.compress) begin
                    ctrl.div_start = 1'b1;
                    state_next = S_SDIV;
                end else state_next = S_EMIT;
            end
            S_SDIV: begin
                ctrl.div_sel = ebc_pkg::DIV_SHARE;
                if (stat.div_done) state_next = S_MUL;
            end
            S_MUL: begin
                ctrl.mul_start = 1'b1;
                state_next = S_OUTF;
            end
            S_OUTF: if (stat.mul_done) state_next = S_EMIT;
            S_EMIT: begin
                if (!stat.out_busy) begin
                    ctrl.emit_dyn = 1'b1;
                    slot_next = slot_reg + 1'b1;
                    state_next = stat.is_last_slot ? S_IDLE : S_SLOT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            slot_reg <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg <= slot_next;
        end
    end
endmodule

// File: design/elastic_bandwidth_compressor.sv
// Elastic bandwidth compressor.
// Input channel s_valid/s_ready/s_data carries one command word: add fixed
// task, add dynamic task, remove task or recompute. Result channel
// m_valid/m_ready/m_data carries task parameter words; last marks the final
// word caused by a command. cfg_we/cfg_wdata write total_bandwidth (Q16).
// Operation: one command at a time. Adds run one restoring divide for the
// utilization. Recompute walks the 16 slots to sum, then emits one word
// per dynamic slot; with compression each slot first runs one share divide
// on the shared divider plus one multiply.
// Results leave through one output register; a stalled receiver holds the
// sequencer at its next emit, no word is lost.
// Reset (synchronous, aresetn low) clears both tables' valid bits and
// restores total_bandwidth to 62259.
module elastic_bandwidth_compressor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ebc_pkg::in_word_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ebc_pkg::out_word_t          m_data,
    input  logic                        cfg_we,
    input  logic [ebc_pkg::BW_W-1:0]    cfg_wdata
);
    ebc_pkg::ctrl_t ctrl;
    ebc_pkg::stat_t stat;

    ebc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .ctrl(ctrl)
    );

    ebc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .s_data(s_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .m_data(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule

// File: design/ebc_checker.sv
// Port-level checks
module ebc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input ebc_pkg::out_word_t m_data
);
    // one command at a time: no new accept right after one
    a_no_back_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accept twice");

    // output held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))) else $error("out drop");

    // no result word the cycle after an accept
    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid) else $error("early word");

    // input stays closed while a burst has more words to come
    a_ready_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready) else $error("ready mid burst");
endmodule

bind elastic_bandwidth_compressor ebc_checker u_ebc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// File: test/tb_elastic_bandwidth_compressor.sv
`timescale 1ns / 100ps

module tb_elastic_bandwidth_compressor;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int N_RANDOM       = 75;

    localparam int MAX_TASKS      = ebc_pkg::MAX_TASKS;
    localparam int ID_W           = ebc_pkg::ID_W;
    localparam int UTIL_W         = ebc_pkg::UTIL_W;
    localparam int UTIL_FRAC_BITS = ebc_pkg::UTIL_FRAC_BITS;
    localparam int BW_W           = ebc_pkg::BW_W;

    // ------------------------------------------------------------------
    // Task-table predictor and store of expected parameter words
    // ------------------------------------------------------------------
    class task_table_predictor;
        bit              fix_used[MAX_TASKS];
        bit [ID_W-1:0]   fix_id[MAX_TASKS];
        bit [UTIL_W-1:0] fix_util[MAX_TASKS];
        bit              dyn_used[MAX_TASKS];
        bit [ID_W-1:0]   dyn_id[MAX_TASKS];
        bit [UTIL_W-1:0] dyn_util[MAX_TASKS];
        bit [31:0]       dyn_per[MAX_TASKS];
        bit [31:0]       dyn_rt[MAX_TASKS];
        bit [BW_W-1:0]   bandwidth;
        ebc_pkg::out_word_t pending[$];
        int              n_words;
        int              n_bad;
        int              n_recompress;

        function void clear();
            for (int i = 0; i < MAX_TASKS; i++) begin
                fix_used[i] = 0;
                dyn_used[i] = 0;
            end
            bandwidth = ebc_pkg::BW_RESET;
            pending.delete();
            n_words = 0;
            n_bad = 0;
            n_recompress = 0;
        endfunction

        function bit [UTIL_W-1:0] utilization(bit [31:0] rt, bit [31:0] per);
            bit [63:0] q;
            if (per == 0) return UTIL_W'(1 << UTIL_FRAC_BITS);
            q = ({32'd0, rt} << UTIL_FRAC_BITS) / per;
            if (q > (64'd1 << UTIL_FRAC_BITS)) q = 64'd1 << UTIL_FRAC_BITS;
            return q[UTIL_W-1:0];
        endfunction

        // returns matching slot, else lowest free, else -1
        function int pick_fixed(bit [ID_W-1:0] id);
            for (int i = 0; i < MAX_TASKS; i++)
                if (fix_used[i] && fix_id[i] == id) return i;
            for (int i = 0; i < MAX_TASKS; i++)
                if (!fix_used[i]) return i;
            return -1;
        endfunction

        function int pick_dyn(bit [ID_W-1:0] id);
            for (int i = 0; i < MAX_TASKS; i++)
                if (dyn_used[i] && dyn_id[i] == id) return i;
            for (int i = 0; i < MAX_TASKS; i++)
                if (!dyn_used[i]) return i;
            return -1;
        endfunction

        function void note_command(ebc_pkg::in_word_t w);
            int s;
            int last_slot;
            longint uf, ud, resid, excess, un;
            longint unsigned tsum, share;
            bit squeeze;
            ebc_pkg::out_word_t o;
            case (w.kind)
                ebc_pkg::KIND_ADD_FIXED: begin
                    s = pick_fixed(w.task_id);
                    if (s >= 0) begin
                        fix_used[s] = 1;
                        fix_id[s] = w.task_id;
                        fix_util[s] = utilization(w.runtime, w.period);
                    end
                    o.out_task_id = w.task_id;
                    o.out_period = w.period;
                    o.out_deadline = w.deadline;
                    o.out_runtime = w.runtime;
                    o.last = 1'b1;
                    pending = {pending, o};
                end
                ebc_pkg::KIND_ADD_DYN: begin
                    s = pick_dyn(w.task_id);
                    if (s >= 0) begin
                        dyn_used[s] = 1;
                        dyn_id[s] = w.task_id;
                        dyn_util[s] = utilization(w.runtime, w.period);
                        dyn_per[s] = w.period;
                        dyn_rt[s] = w.runtime;
                    end
                end
                ebc_pkg::KIND_REMOVE: begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (fix_used[i] && fix_id[i] == w.task_id) fix_used[i] = 0;
                        if (dyn_used[i] && dyn_id[i] == w.task_id) dyn_used[i] = 0;
                    end
                end
                default: begin
                    uf = 0;
                    ud = 0;
                    tsum = 0;
                    last_slot = -1;
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (fix_used[i]) uf += fix_util[i];
                        if (dyn_used[i]) begin
                            ud += dyn_util[i];
                            tsum += dyn_per[i];
                            last_slot = i;
                        end
                    end
                    resid = longint'(bandwidth) - uf;
                    squeeze = resid < ud;
                    excess = squeeze ? ud - resid : 0;
                    if (squeeze && last_slot >= 0) n_recompress++;
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (!dyn_used[i]) continue;
                        o.out_task_id = dyn_id[i];
                        o.out_period = dyn_per[i];
                        o.out_deadline = dyn_per[i];
                        if (squeeze) begin
                            share = tsum ? (longint'(excess) * dyn_per[i]) / tsum : 0;
                            un = longint'(dyn_util[i]) - longint'(share);
                            o.out_runtime = (un <= 0) ? 32'd0
                                : 32'((longint'(un) * dyn_per[i]) >> UTIL_FRAC_BITS);
                        end else begin
                            o.out_runtime = dyn_rt[i];
                        end
                        o.last = (i == last_slot);
                        pending = {pending, o};
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH word %0d %s", n_words, msg);
            n_bad++;
        endtask

        task check_word(ebc_pkg::out_word_t got);
            ebc_pkg::out_word_t want;
            if (pending.size() == 0) begin
                report("arrived with nothing expected");
                n_words++;
                return;
            end
            want = pending.pop_front();
            if (got.out_task_id != want.out_task_id)
                report($sformatf("task_id: got %0h expected %0h",
                                 got.out_task_id, want.out_task_id));
            if (got.out_period != want.out_period)
                report($sformatf("period: got %0h expected %0h",
                                 got.out_period, want.out_period));
            if (got.out_deadline != want.out_deadline)
                report($sformatf("deadline: got %0h expected %0h",
                                 got.out_deadline, want.out_deadline));
            if (got.out_runtime != want.out_runtime)
                report($sformatf("runtime: got %0h expected %0h",
                                 got.out_runtime, want.out_runtime));
            if (got.last !== want.last)
                report($sformatf("last: got %0h expected %0h", got.last, want.last));
            n_words++;
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    ebc_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    ebc_pkg::out_word_t m_data;
    logic               cfg_we;
    logic [BW_W-1:0]    cfg_wdata;

    task_table_predictor tables;
    int  n_commands;
    int  idle_cycles;
    bit  rx_hold;
    bit  rx_gaps;
    bit  [ID_W-1:0] id_pool[8];

    elastic_bandwidth_compressor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // sample handshakes at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tables.note_command(s_data);
            if (m_valid && m_ready) tables.check_word(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** elastic_bandwidth_compressor: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        int g;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (3000) @(negedge aclk);
                rx_hold = 0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(ebc_pkg::in_word_t w, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        // valid drops between words
        @(negedge aclk);
        repeat (g) @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_commands++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_cmd(logic [1:0] k, logic [ID_W-1:0] id, logic [31:0] rt,
                            logic [31:0] dl, logic [31:0] per, bit gaps);
        ebc_pkg::in_word_t w;
        w.kind = k;
        w.task_id = id;
        w.runtime = rt;
        w.deadline = dl;
        w.period = per;
        send_word(w, gaps);
    endtask

    // wait for every expected word, then past the longest recompute
    task automatic drain();
        while (tables.pending.size() != 0) @(negedge aclk);
        repeat (1300) @(negedge aclk);
    endtask

    task automatic set_bandwidth(logic [BW_W-1:0] bw);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= bw;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tables.bandwidth = bw;
    endtask

    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 100);
            default: return $urandom_range(1000, 10_000_000);
        endcase
    endfunction

    function automatic logic [31:0] rand_runtime(logic [31:0] per);
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return (per == 0) ? $urandom_range(0, 1000) : $urandom_range(0, per);
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [1:0]      k;
        logic [ID_W-1:0] id;
        logic [31:0]     per;
        int              r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      k = ebc_pkg::KIND_ADD_DYN;
            else if (r < 50) k = ebc_pkg::KIND_ADD_FIXED;
            else if (r < 65) k = ebc_pkg::KIND_REMOVE;
            else             k = ebc_pkg::KIND_RECOMPUTE;
            // mostly reuse a small id pool so overwrite and remove hit
            id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom()) : id_pool[$urandom_range(0, 7)];
            per = rand_period();
            send_cmd(k, id, rand_runtime(per), $urandom(), per, 1'b1);
        end
    endtask

    initial begin
        tables = new();
        tables.clear();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        idle_cycles = 0;
        n_commands = 0;
        rx_hold = 0;
        rx_gaps = 0;
        for (int i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom());
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty recompute, field extremes, overwrite, zero period
        send_cmd(ebc_pkg::KIND_RECOMPUTE, '0, '0, '0, 32'd1, 1'b0);
        send_cmd(ebc_pkg::KIND_ADD_FIXED, '1, '1, '1, '1, 1'b0);
        send_cmd(ebc_pkg::KIND_ADD_FIXED, '0, '0, '0, 32'd0, 1'b0);
        send_cmd(ebc_pkg::KIND_ADD_DYN, 22'h15_5555, 32'd300, '0, 32'd1000, 1'b0);
        send_cmd(ebc_pkg::KIND_ADD_DYN, 22'h2A_AAAA, 32'd0, '1, 32'd0, 1'b0);
        send_cmd(ebc_pkg::KIND_ADD_DYN, 22'h15_5555, 32'd500, '0, 32'd2000, 1'b0);
        send_cmd(ebc_pkg::KIND_RECOMPUTE, '0, '0, '0, '0, 1'b0);
        send_cmd(ebc_pkg::KIND_REMOVE, '0, '0, '0, '0, 1'b0);
        send_cmd(ebc_pkg::KIND_REMOVE, 22'h12_3456, '0, '0, '0, 1'b0);
        send_cmd(ebc_pkg::KIND_RECOMPUTE, '0, '0, '0, '0, 1'b0);
        send_cmd(ebc_pkg::KIND_REMOVE, 22'h2A_AAAA, '0, '0, '0, 1'b0);
        // add MAX_TASKS + 1 tasks, alternating dynamic and fixed
        for (int i = 0; i < MAX_TASKS + 1; i++)
            send_cmd((i % 2) ? ebc_pkg::KIND_ADD_FIXED : ebc_pkg::KIND_ADD_DYN,
                     ID_W'(i + 100), 32'd1000, 32'd5000, 32'd8000, 1'b0);
        set_bandwidth('1);
        send_cmd(ebc_pkg::KIND_RECOMPUTE, '0, '0, '0, '0, 1'b0);
        set_bandwidth('0);
        send_cmd(ebc_pkg::KIND_RECOMPUTE, '0, '0, '0, '0, 1'b0);

        // pressure: receiver holds off while recomputes pile up
        for (int i = 0; i < MAX_TASKS + 2; i++)
            send_cmd(ebc_pkg::KIND_ADD_DYN, ID_W'(i + 100), 32'd4000, '0, 32'd8000, 1'b0);
        rx_hold = 1;
        repeat (4) send_cmd(ebc_pkg::KIND_RECOMPUTE, '0, '0, '0, '0, 1'b0);
        drain();
        for (int i = 0; i < MAX_TASKS + 2; i++)
            send_cmd(ebc_pkg::KIND_REMOVE, ID_W'(i + 100), '0, '0, '0, 1'b0);

        // random phases across several bandwidth settings
        rx_gaps = 1;
        set_bandwidth(BW_W'(4194304));
        random_phase(N_RANDOM / 3);
        set_bandwidth(BW_W'(32768));
        random_phase(N_RANDOM / 3);
        set_bandwidth(BW_W'($urandom_range(0, 200000)));
        random_phase(N_RANDOM / 3);
        set_bandwidth(BW_W'(1));
        random_phase(10);
        drain();

        $display("Run covered %0d commands and %0d parameter words, %0d compressing recomputes.",
                 n_commands, tables.n_words, tables.n_recompress);
        if (tables.n_bad == 0 && tables.pending.size() == 0) begin
            $display("** elastic_bandwidth_compressor: PASSED **");
        end else begin
            $display("%0d mismatches, %0d words still expected", tables.n_bad,
                     tables.pending.size());
            $display("** elastic_bandwidth_compressor: FAILED **");
        end
        $finish;
    end

endmodule
